[hdl/pwsd_pkg.sv]
package pwsd_pkg;

	// message length limit, default for the top level parameter
	localparam int MAX_MESSAGE_DEF = 256;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_MARK_WINDOWS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPACE_WINDOWS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BITS     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_BITS     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MSB_FIRST     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_PARITY_MODE   = 3'd6;
	localparam int CFG_DATA_W = 64;

	// configuration reset values
	localparam logic [63:0] MARK_WINDOWS_RST  = 64'd0;
	localparam logic [63:0] SPACE_WINDOWS_RST = 64'd0;
	localparam logic [15:0] IDLE_LIMIT_RST    = 16'd65535;
	localparam logic [7:0]  SYNC_BITS_RST     = 8'd10;
	localparam logic [3:0]  DATA_BITS_RST     = 4'd8;
	localparam logic        MSB_FIRST_RST     = 1'b0;
	localparam logic [2:0]  PARITY_MODE_RST   = 3'd0;

	// parity modes, anything above even counts as odd
	localparam logic [2:0] PAR_NONE  = 3'd0;
	localparam logic [2:0] PAR_MARK  = 3'd1;
	localparam logic [2:0] PAR_SPACE = 3'd2;
	localparam logic [2:0] PAR_EVEN  = 3'd3;

	// line level bit of a sample
	localparam int LEVEL_BIT = 7;

	typedef struct packed {
		logic [63:0] mark_windows;
		logic [63:0] space_windows;
		logic [15:0] idle_limit;
		logic [7:0]  sync_bits;
		logic [3:0]  data_bits;
		logic        msb_first;
		logic [2:0]  parity_mode;
	} cfg_t;

	typedef struct packed {
		logic mark_one;
		logic mark_zero;
		logic space_one;
		logic space_zero;
	} votes_t;

	// event from the run meter to the framer
	typedef struct packed {
		logic reset_frame;
		logic bit_valid;
		logic bit_value;
		logic idle_gap;
	} run_evt_t;

	// one 16-bit limit out of a packed window word
	function automatic logic [15:0] win_field(logic [63:0] w, logic [1:0] k);
		return w[{k, 4'b0000} +: 16];
	endfunction

	// strict window test, sel picks the one pair or the zero pair
	function automatic logic in_window(logic [15:0] len, logic [63:0] w, logic sel);
		return (len > win_field(w, {sel, 1'b0})) && (len < win_field(w, {sel, 1'b1}));
	endfunction

endpackage

[hdl/pulse_width_serial_decoder_unit.sv]
// a request passes the input register and then the result register, and a stall can hold it in either
// throughput: one request per cycle while out_stall is low, the single pass of run, vote and frame logic sets it
// the input side keeps accepting while a result waits, it stalls only when both registers are full
// reset (arst_n low, asynchronous): run, vote and frame state clear, configuration to defaults
// no clearing pass after reset, the block accepts requests in the first cycle
module pulse_width_serial_decoder_unit
	import pwsd_pkg::*;
#(
	parameter int MAX_MESSAGE = MAX_MESSAGE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_wr,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// sample requests
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            sample,
	// decoded results
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  byte_valid,
	output logic [7:0]            data,
	output logic                  message_end,
	output logic                  at_work
);

	// configuration registers
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mark_windows <= MARK_WINDOWS_RST;
			cfg_q.space_windows <= SPACE_WINDOWS_RST;
			cfg_q.idle_limit <= IDLE_LIMIT_RST;
			cfg_q.sync_bits <= SYNC_BITS_RST;
			cfg_q.data_bits <= DATA_BITS_RST;
			cfg_q.msb_first <= MSB_FIRST_RST;
			cfg_q.parity_mode <= PARITY_MODE_RST;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				CFG_MARK_WINDOWS:  cfg_q.mark_windows <= cfg_data;
				CFG_SPACE_WINDOWS: cfg_q.space_windows <= cfg_data;
				CFG_IDLE_LIMIT:    cfg_q.idle_limit <= cfg_data[15:0];
				CFG_SYNC_BITS:     cfg_q.sync_bits <= cfg_data[7:0];
				CFG_DATA_BITS:     cfg_q.data_bits <= cfg_data[3:0];
				CFG_MSB_FIRST:     cfg_q.msb_first <= cfg_data[0];
				CFG_PARITY_MODE:   cfg_q.parity_mode <= cfg_data[2:0];
				default:           ;  // unused index, write dropped
			endcase
		end
	end

	// stage 1: input register
	logic       valid_s1;
	logic [7:0] sample_s1;
	// stage 2: result register
	logic       valid_s2;
	logic       byte_valid_s2;
	logic [7:0] data_s2;
	logic       message_end_s2;
	logic       at_work_s2;

	// the stage 1 request moves on when the result register is empty or drains now
	logic adv;
	logic in_acc;

	assign adv = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_acc = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_s1 <= sample;
		end
	end

	// run length, level tracking and bit voting
	run_evt_t evt;

	pwsd_run u_run (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.hi     (sample_s1[LEVEL_BIT]),
		.cfg    (cfg_q),
		.evt    (evt)
	);

	// sync, character assembly, parity and message bookkeeping
	logic       fr_byte_valid;
	logic [7:0] fr_data;
	logic       fr_message_end;
	logic       fr_at_work;

	pwsd_framer #(
		.MAX_MESSAGE (MAX_MESSAGE)
	) u_framer (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv),
		.cfg         (cfg_q),
		.evt         (evt),
		.byte_valid  (fr_byte_valid),
		.data        (fr_data),
		.message_end (fr_message_end),
		.at_work     (fr_at_work)
	);

	// result register, holds while the consumer stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_valid_s2 <= fr_byte_valid;
			data_s2 <= fr_data;
			message_end_s2 <= fr_message_end;
			at_work_s2 <= fr_at_work;
		end
	end

	assign out_valid = valid_s2;
	assign byte_valid = byte_valid_s2;
	assign data = data_s2;
	assign message_end = message_end_s2;
	assign at_work = at_work_s2;

endmodule

[hdl/pwsd_run.sv]
module pwsd_run
	import pwsd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     hi,
	input  cfg_t     cfg,
	output run_evt_t evt
);

	logic [15:0] run_count_q;
	logic        last_level_q;
	votes_t      votes_q;

	logic [15:0] run_count_d;
	logic        last_level_d;
	votes_t      votes_d;

	always_comb begin
		logic [15:0] len;
		logic        ex;
		logic [1:0]  ones;
		logic [1:0]  zeros;
		votes_t      v;
		len = run_count_q + 16'd1;
		ex = (len >= cfg.idle_limit);
		v = votes_q;
		ones = 2'd0;
		zeros = 2'd0;
		evt = '0;
		evt.idle_gap = ex;
		run_count_d = len;
		last_level_d = last_level_q;
		votes_d = votes_q;
		if (ex || (hi != last_level_q)) begin
			run_count_d = '0;
			if (ex && last_level_q) begin
				// idle after a high level drops the frame at once
				evt.reset_frame = 1'b1;
			end else begin
				if (ex) begin
					if (win_field(cfg.space_windows, 2'd1) > win_field(cfg.space_windows, 2'd3))
						v.mark_one = 1'b1;
					else
						v.mark_zero = 1'b1;
				end else if (hi) begin
					if (in_window(len, cfg.space_windows, 1'b0)) v.space_one = 1'b1;
					if (in_window(len, cfg.space_windows, 1'b1)) v.space_zero = 1'b1;
				end else begin
					if (in_window(len, cfg.mark_windows, 1'b0)) v.mark_one = 1'b1;
					if (in_window(len, cfg.mark_windows, 1'b1)) v.mark_zero = 1'b1;
				end
				last_level_d = hi;
				votes_d = v;
				if (hi || ex) begin
					// decide the bit from the collected votes
					ones = {1'b0, v.mark_one} + {1'b0, v.space_one};
					zeros = {1'b0, v.mark_zero} + {1'b0, v.space_zero};
					votes_d = '0;
					if (ones == zeros) begin
						evt.reset_frame = 1'b1;
					end else begin
						evt.bit_valid = 1'b1;
						evt.bit_value = (ones > zeros);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_count_q <= '0;
			last_level_q <= 1'b0;
			votes_q <= '0;
		end else if (en) begin
			run_count_q <= run_count_d;
			last_level_q <= last_level_d;
			votes_q <= votes_d;
		end
	end

endmodule

[hdl/pwsd_framer.sv]
module pwsd_framer
	import pwsd_pkg::*;
#(
	parameter int MAX_MESSAGE = MAX_MESSAGE_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  cfg_t     cfg,
	input  run_evt_t evt,
	output logic     byte_valid,
	output logic [7:0] data,
	output logic     message_end,
	output logic     at_work
);

	localparam int MLW = $clog2(MAX_MESSAGE + 1);

	logic           synced_q;
	logic [7:0]     bit_count_q;
	logic [7:0]     shift_byte_q;
	logic [MLW-1:0] message_length_q;

	logic           synced_d;
	logic [7:0]     bit_count_d;
	logic [7:0]     shift_byte_d;
	logic [MLW-1:0] message_length_d;

	always_comb begin
		logic rst;
		logic deliver;
		logic par;
		rst = evt.reset_frame;
		deliver = 1'b0;
		par = ^shift_byte_q;
		synced_d = synced_q;
		bit_count_d = bit_count_q;
		shift_byte_d = shift_byte_q;
		message_length_d = message_length_q;
		byte_valid = 1'b0;
		data = 8'd0;
		message_end = 1'b0;
		if (!evt.reset_frame && evt.bit_valid) begin
			if (!synced_q) begin
				// hunting for the sync run, counter wraps at 256
				bit_count_d = bit_count_q + 8'd1;
				if (evt.bit_value) begin
					if (bit_count_d >= cfg.sync_bits) synced_d = 1'b1;
					bit_count_d = '0;
				end
			end else if (bit_count_q < {4'b0000, cfg.data_bits}) begin
				if (cfg.msb_first)
					shift_byte_d = {shift_byte_q[6:0], evt.bit_value};
				else if (evt.bit_value && (bit_count_q[7:3] == 5'd0))
					shift_byte_d[bit_count_q[2:0]] = 1'b1;
				bit_count_d = bit_count_q + 8'd1;
				deliver = (cfg.parity_mode == PAR_NONE) &&
					(bit_count_d >= {4'b0000, cfg.data_bits});
			end else if (cfg.parity_mode != PAR_NONE) begin
				case (cfg.parity_mode)
					PAR_MARK:  rst = !evt.bit_value;
					PAR_SPACE: rst = evt.bit_value;
					PAR_EVEN:  rst = (par != evt.bit_value);
					default:   rst = (par == evt.bit_value);
				endcase
				deliver = !rst;
			end else begin
				// no data bits configured: empty byte
				deliver = 1'b1;
			end
			if (deliver) begin
				if (message_length_q >= MLW'(MAX_MESSAGE)) begin
					rst = 1'b1;
				end else begin
					byte_valid = 1'b1;
					data = shift_byte_d;
					message_length_d = message_length_q + MLW'(1);
					shift_byte_d = '0;
					bit_count_d = '0;
					rst = evt.idle_gap;
				end
			end
		end
		if (rst) begin
			message_end = (message_length_d != '0);
			message_length_d = '0;
			shift_byte_d = '0;
			bit_count_d = '0;
			synced_d = 1'b0;
		end
		at_work = synced_d || (bit_count_d > 8'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			synced_q <= 1'b0;
			bit_count_q <= '0;
			shift_byte_q <= '0;
			message_length_q <= '0;
		end else if (en) begin
			synced_q <= synced_d;
			bit_count_q <= bit_count_d;
			shift_byte_q <= shift_byte_d;
			message_length_q <= message_length_d;
		end
	end

endmodule
